### sv/tangent_space_generator_defines.svh
// assertion macros for the tangent space generator checker
// needs clk and rst in the scope where a macro is used
`ifndef TANGENT_SPACE_GENERATOR_DEFINES_SVH
`define TANGENT_SPACE_GENERATOR_DEFINES_SVH

// same-cycle implication, off during reset
`define TSG_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tsg check failed");

// next-cycle implication, off during reset
`define TSG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tsg check failed");

// condition in the cycle after reset is seen
`define TSG_ASSERT_RESET(lbl, cons) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("tsg check failed");

`endif

### sv/tsg_pkg.sv
// shared types, widths and state encodings of the tangent space generator
// used by tsg_norm and tangent_space_generator
package tsg_pkg;

  localparam int COORD_BITS = 16;
  localparam int IN_W       = 16;
  localparam int OUT_W      = 16;
  localparam int CFG_W      = 3;
  localparam int EDGE_W     = IN_W + 1;
  localparam int PROD_W     = 2 * EDGE_W;
  localparam int VEC_W      = PROD_W + 1;
  localparam int IN_FIELDS  = 8;
  localparam int OUT_FIELDS = 6;
  localparam int S_DATA_W   = IN_FIELDS * IN_W;
  localparam int M_DATA_W   = OUT_FIELDS * OUT_W;

  localparam int UP_SHIFT   = (COORD_BITS < IN_W) ? IN_W - COORD_BITS : 0;
  localparam int DOWN_SHIFT = (COORD_BITS > IN_W) ? COORD_BITS - IN_W : 0;

  localparam logic [CFG_W-1:0] GROUP_TRI  = 3'd3;
  localparam logic [CFG_W-1:0] GROUP_QUAD = 3'd4;
  localparam logic [2:0]       ISSUE_LAST = 3'd5;

  typedef logic signed [VEC_W-1:0] vec_t;
  typedef logic signed [OUT_W-1:0] coord_t;

  typedef struct packed {
    logic start;
    vec_t x;
    vec_t y;
    vec_t z;
  } norm_req_t;

  typedef struct packed {
    logic   done;
    coord_t x;
    coord_t y;
    coord_t z;
  } norm_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_DRAIN,
    ST_NSTART,
    ST_NWAIT,
    ST_EMIT
  } st_t;

  typedef enum logic [1:0] {
    JOB_TA,
    JOB_TB,
    JOB_CA,
    JOB_CB
  } job_t;

  typedef enum logic [2:0] {
    N_IDLE,
    N_SCALE,
    N_SQUARE,
    N_ROOT,
    N_DSETUP,
    N_DIVIDE,
    N_DONE
  } nst_t;

  // bring a raw coordinate to the internal 16 bit format
  function automatic logic signed [IN_W-1:0] take_coord(input logic [IN_W-1:0] raw);
    logic [IN_W-1:0] bits;
    bits = (COORD_BITS <= IN_W) ? (raw << UP_SHIFT) : (raw >> DOWN_SHIFT);
    return signed'(bits);
  endfunction

endpackage

### sv/tsg_norm.sv
// iterative vector normalizer: scale, sum of squares, bitwise root, restoring divide
// depends on tsg_pkg
module tsg_norm (
  input  logic              clk,
  input  logic              rst,
  input  tsg_pkg::norm_req_t req,
  output tsg_pkg::norm_rsp_t rsp
);

  localparam int MAG_W  = tsg_pkg::VEC_W;
  localparam int ROOT_W = 64;
  localparam int REM_W  = 47;

  tsg_pkg::nst_t nst, nst_next;

  logic [MAG_W-1:0]  mag [3];
  logic [2:0]        neg;
  logic [1:0]        cidx;
  logic [ROOT_W-1:0] sum, rx, rr, rbit;
  logic [REM_W-1:0]  rem;
  logic [14:0]       q;
  logic [3:0]        dstep;
  tsg_pkg::coord_t   res [3];

  logic [MAG_W-1:0]  m;
  logic [MAG_W-1:0]  in_mag [3];
  logic [59:0]       sq;
  logic [ROOT_W-1:0] sum_acc, trial;
  logic [REM_W-1:0]  den_sh;
  logic              hit;
  logic [14:0]       q_fin;
  logic              in_zero;

  always_comb begin
    in_mag[0] = req.x[MAG_W-1] ? MAG_W'(-req.x) : MAG_W'(req.x);
    in_mag[1] = req.y[MAG_W-1] ? MAG_W'(-req.y) : MAG_W'(req.y);
    in_mag[2] = req.z[MAG_W-1] ? MAG_W'(-req.z) : MAG_W'(req.z);
    in_zero = (req.x == '0) && (req.y == '0) && (req.z == '0);
    m = mag[0];
    if (mag[1] > m) m = mag[1];
    if (mag[2] > m) m = mag[2];
    sq = 60'(mag[cidx][29:0]) * 60'(mag[cidx][29:0]);
    sum_acc = sum + ROOT_W'(sq);
    trial = rr + rbit;
    den_sh = REM_W'({rr[31:0], 1'b0}) << dstep;
    hit = rem >= den_sh;
    q_fin = q | (15'(hit) << dstep);
  end

  always_comb begin
    nst_next = nst;
    unique case (nst)
      tsg_pkg::N_IDLE:   if (req.start) nst_next = in_zero ? tsg_pkg::N_DONE : tsg_pkg::N_SCALE;
      tsg_pkg::N_SCALE: begin
        if (m < MAG_W'(64'h4000_0000) && m >= MAG_W'(64'h2000_0000)) nst_next = tsg_pkg::N_SQUARE;
      end
      tsg_pkg::N_SQUARE: if (cidx == 2'd2) nst_next = tsg_pkg::N_ROOT;
      tsg_pkg::N_ROOT:   if (rbit == ROOT_W'(1)) nst_next = tsg_pkg::N_DSETUP;
      tsg_pkg::N_DSETUP: nst_next = tsg_pkg::N_DIVIDE;
      tsg_pkg::N_DIVIDE: begin
        if (dstep == 4'd0) nst_next = (cidx == 2'd2) ? tsg_pkg::N_DONE : tsg_pkg::N_DSETUP;
      end
      tsg_pkg::N_DONE:   nst_next = tsg_pkg::N_IDLE;
      default:           nst_next = tsg_pkg::N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nst <= tsg_pkg::N_IDLE;
    end else begin
      nst <= nst_next;
    end
  end

  always_ff @(posedge clk) begin
    case (nst)
      tsg_pkg::N_IDLE: begin
        if (req.start) begin
          mag[0] <= in_mag[0];
          mag[1] <= in_mag[1];
          mag[2] <= in_mag[2];
          neg    <= {req.z[MAG_W-1], req.y[MAG_W-1], req.x[MAG_W-1]};
          res[0] <= '0;
          res[1] <= '0;
          res[2] <= '0;
        end
      end
      tsg_pkg::N_SCALE: begin
        for (int k = 0; k < 3; k++) begin
          if (m >= MAG_W'(64'h4_0000_0000)) mag[k] <= mag[k] >> 4;
          else if (m >= MAG_W'(64'h4000_0000)) mag[k] <= mag[k] >> 1;
          else if (m < MAG_W'(64'h200_0000)) mag[k] <= mag[k] << 4;
          else if (m < MAG_W'(64'h2000_0000)) mag[k] <= mag[k] << 1;
        end
        cidx <= 2'd0;
        sum  <= '0;
      end
      tsg_pkg::N_SQUARE: begin
        if (cidx == 2'd2) begin
          rx   <= sum_acc;
          rr   <= '0;
          rbit <= ROOT_W'(1) << 62;
          cidx <= 2'd0;
        end else begin
          sum  <= sum_acc;
          cidx <= cidx + 2'd1;
        end
      end
      tsg_pkg::N_ROOT: begin
        if (rx >= trial) begin
          rx <= rx - trial;
          rr <= (rr >> 1) + rbit;
        end else begin
          rr <= rr >> 1;
        end
        rbit <= rbit >> 2;
      end
      tsg_pkg::N_DSETUP: begin
        rem   <= (REM_W'(mag[cidx][29:0]) << 15) + REM_W'(rr[31:0]);
        dstep <= 4'd14;
        q     <= '0;
      end
      tsg_pkg::N_DIVIDE: begin
        if (hit) rem <= rem - den_sh;
        q <= q_fin;
        if (dstep == 4'd0) begin
          res[cidx] <= neg[cidx] ? -tsg_pkg::OUT_W'(q_fin) : tsg_pkg::OUT_W'(q_fin);
          cidx      <= cidx + 2'd1;
        end else begin
          dstep <= dstep - 4'd1;
        end
      end
      default: ;
    endcase
  end

  assign rsp.done = (nst == tsg_pkg::N_DONE);
  assign rsp.x    = res[0];
  assign rsp.y    = res[1];
  assign rsp.z    = res[2];

endmodule

### sv/tangent_space_generator.sv
// Per-face tangent generator. Vertices are taken one per transaction while
// s_tready is high. When a group closes, the block is busy: each of the
// 2 + 2n normalizations (n = 3 or 4 vertices, two per vertex) runs on one
// shared iterative unit (scaling, squares, root one bit pair a cycle, divide
// one quotient bit a cycle per component, done; a zero vector goes straight
// to done), with a product phase before each and one emit per vertex. A
// finished result waits in the output register while the next vertices are
// accepted. Writing group_size drops a partial group. Depends on tsg_pkg and
// tsg_norm.
module tangent_space_generator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tsg_pkg::CFG_W-1:0]     cfg_wdata,  // group_size
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, tex_u, tex_v
  input  logic [tsg_pkg::S_DATA_W-1:0]  s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // tan_a_x, tan_a_y, tan_a_z, tan_b_x, tan_b_y, tan_b_z
  output logic [tsg_pkg::M_DATA_W-1:0]  m_tdata,
  output logic                          m_tlast     // group_end
);

  localparam int IW = tsg_pkg::IN_W;
  localparam int EW = tsg_pkg::EDGE_W;

  tsg_pkg::st_t  state, state_next;
  tsg_pkg::job_t job, job_next;
  logic [2:0]    cnt, cnt_next;
  logic [1:0]    vtx, vtx_next;
  logic [2:0]    group_size, fill_count;

  logic signed [IW-1:0] pos [3][3];
  logic signed [IW-1:0] uv  [3][2];
  logic signed [IW-1:0] nrm [4][3];
  tsg_pkg::coord_t      t0 [3];
  tsg_pkg::coord_t      t1 [3];
  tsg_pkg::coord_t      ahold [3];
  tsg_pkg::coord_t      bhold [3];
  tsg_pkg::vec_t        vec [3];

  logic signed [tsg_pkg::PROD_W-1:0] prod;
  logic                 prod_v, prod_sub;
  logic [1:0]           prod_i;

  tsg_pkg::norm_req_t   nreq;
  tsg_pkg::norm_rsp_t   nrsp;

  logic                 in_acc, last_in, load_out, vtx_last, nstart;
  logic [2:0]           gs_n, in_idx;
  logic [1:0]           ci, i1, i2;
  logic                 sub;
  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];
  logic signed [EW-1:0] nv [3];
  logic signed [EW-1:0] tsel [3];
  logic signed [EW-1:0] d1u, d1v, d2u, d2v, op_a, op_b;
  logic signed [IW-1:0] in_f [8];

  assign s_tready = (state == tsg_pkg::ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign gs_n     = (group_size == tsg_pkg::GROUP_QUAD) ? tsg_pkg::GROUP_QUAD : tsg_pkg::GROUP_TRI;
  assign in_idx   = (fill_count >= gs_n) ? 3'd0 : fill_count;
  assign last_in  = (in_idx + 3'd1) >= gs_n;
  assign vtx_last = ({1'b0, vtx} + 3'd1) == gs_n;
  assign ci       = cnt[2:1];
  assign sub      = cnt[0];

  always_comb begin
    for (int f = 0; f < 8; f++) begin
      in_f[f] = tsg_pkg::take_coord(s_tdata[f*IW +: IW]);
    end
    for (int c = 0; c < 3; c++) begin
      e1[c]   = EW'(pos[1][c]) - EW'(pos[0][c]);
      e2[c]   = EW'(pos[2][c]) - EW'(pos[0][c]);
      nv[c]   = EW'(nrm[vtx][c]);
      tsel[c] = (job == tsg_pkg::JOB_CA) ? EW'(t1[c]) : EW'(t0[c]);
    end
    d1u = EW'(uv[1][0]) - EW'(uv[0][0]);
    d1v = EW'(uv[1][1]) - EW'(uv[0][1]);
    d2u = EW'(uv[2][0]) - EW'(uv[0][0]);
    d2v = EW'(uv[2][1]) - EW'(uv[0][1]);
    case (ci)
      2'd0:    begin i1 = 2'd1; i2 = 2'd2; end
      2'd1:    begin i1 = 2'd2; i2 = 2'd0; end
      default: begin i1 = 2'd0; i2 = 2'd1; end
    endcase
    case (job)
      tsg_pkg::JOB_TA: begin
        op_a = sub ? e2[ci] : e1[ci];
        op_b = sub ? d1v : d2v;
      end
      tsg_pkg::JOB_TB: begin
        op_a = sub ? e2[ci] : e1[ci];
        op_b = sub ? d1u : d2u;
      end
      default: begin
        op_a = sub ? nv[i2] : nv[i1];
        op_b = sub ? tsel[i1] : tsel[i2];
      end
    endcase
  end

  always_comb begin
    state_next = state;
    job_next   = job;
    cnt_next   = cnt;
    vtx_next   = vtx;
    nstart     = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      tsg_pkg::ST_IDLE: begin
        if (in_acc && last_in) begin
          state_next = tsg_pkg::ST_PROD;
          job_next   = tsg_pkg::JOB_TA;
          cnt_next   = 3'd0;
        end
      end
      tsg_pkg::ST_PROD: begin
        if (cnt == tsg_pkg::ISSUE_LAST) begin
          cnt_next   = 3'd0;
          state_next = tsg_pkg::ST_DRAIN;
        end else begin
          cnt_next = cnt + 3'd1;
        end
      end
      tsg_pkg::ST_DRAIN:  state_next = tsg_pkg::ST_NSTART;
      tsg_pkg::ST_NSTART: begin
        nstart     = 1'b1;
        state_next = tsg_pkg::ST_NWAIT;
      end
      tsg_pkg::ST_NWAIT: begin
        if (nrsp.done) begin
          unique case (job)
            tsg_pkg::JOB_TA: begin
              job_next   = tsg_pkg::JOB_TB;
              state_next = tsg_pkg::ST_PROD;
            end
            tsg_pkg::JOB_TB: begin
              job_next   = tsg_pkg::JOB_CA;
              vtx_next   = 2'd0;
              state_next = tsg_pkg::ST_PROD;
            end
            tsg_pkg::JOB_CA: begin
              job_next   = tsg_pkg::JOB_CB;
              state_next = tsg_pkg::ST_PROD;
            end
            default: state_next = tsg_pkg::ST_EMIT;
          endcase
        end
      end
      tsg_pkg::ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          load_out = 1'b1;
          if (vtx_last) begin
            state_next = tsg_pkg::ST_IDLE;
          end else begin
            vtx_next   = vtx + 2'd1;
            job_next   = tsg_pkg::JOB_CA;
            state_next = tsg_pkg::ST_PROD;
          end
        end
      end
      default: state_next = tsg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tsg_pkg::ST_IDLE;
      job        <= tsg_pkg::JOB_TA;
      cnt        <= 3'd0;
      vtx        <= 2'd0;
      group_size <= tsg_pkg::GROUP_TRI;
      fill_count <= 3'd0;
      prod_v     <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state  <= state_next;
      job    <= job_next;
      cnt    <= cnt_next;
      vtx    <= vtx_next;
      prod_v <= (state == tsg_pkg::ST_PROD);
      if (in_acc) fill_count <= last_in ? 3'd0 : in_idx + 3'd1;
      if (cfg_we) begin
        group_size <= cfg_wdata;
        fill_count <= 3'd0;
      end
      if (load_out) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    prod     <= op_a * op_b;
    prod_i   <= ci;
    prod_sub <= sub;
    if (prod_v) begin
      if (!prod_sub) vec[prod_i] <= tsg_pkg::VEC_W'(prod);
      else vec[prod_i] <= vec[prod_i] - tsg_pkg::VEC_W'(prod);
    end
    if (in_acc) begin
      if (in_idx < 3'd3) begin
        pos[in_idx[1:0]][0] <= in_f[0];
        pos[in_idx[1:0]][1] <= in_f[1];
        pos[in_idx[1:0]][2] <= in_f[2];
        uv[in_idx[1:0]][0]  <= in_f[6];
        uv[in_idx[1:0]][1]  <= in_f[7];
      end
      nrm[in_idx[1:0]][0] <= in_f[3];
      nrm[in_idx[1:0]][1] <= in_f[4];
      nrm[in_idx[1:0]][2] <= in_f[5];
    end
    if (state == tsg_pkg::ST_NWAIT && nrsp.done) begin
      case (job)
        tsg_pkg::JOB_TA: begin t0[0] <= nrsp.x; t0[1] <= nrsp.y; t0[2] <= nrsp.z; end
        tsg_pkg::JOB_TB: begin t1[0] <= nrsp.x; t1[1] <= nrsp.y; t1[2] <= nrsp.z; end
        tsg_pkg::JOB_CA: begin ahold[0] <= nrsp.x; ahold[1] <= nrsp.y; ahold[2] <= nrsp.z; end
        default:         begin bhold[0] <= nrsp.x; bhold[1] <= nrsp.y; bhold[2] <= nrsp.z; end
      endcase
    end
    if (load_out) begin
      m_tdata <= {bhold[2], bhold[1], bhold[0], ahold[2], ahold[1], ahold[0]};
      m_tlast <= vtx_last;
    end
  end

  assign nreq.start = nstart;
  assign nreq.x     = vec[0];
  assign nreq.y     = vec[1];
  assign nreq.z     = vec[2];

  tsg_norm u_norm (
    .clk (clk),
    .rst (rst),
    .req (nreq),
    .rsp (nrsp)
  );

endmodule

### sv/tsg_checker.sv
// port-level checks for the tangent space generator, bound to the top level
// depends on tangent_space_generator_defines.svh and tsg_pkg
`include "tangent_space_generator_defines.svh"

module tsg_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         cfg_we,
  input logic [tsg_pkg::CFG_W-1:0]    cfg_wdata,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic [tsg_pkg::S_DATA_W-1:0] s_tdata,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [tsg_pkg::M_DATA_W-1:0] m_tdata,
  input logic                         m_tlast
);

  // no result right after reset
  `TSG_ASSERT_RESET(a_rst_empty, !m_tvalid)
  // a stalled result stays put
  `TSG_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
  // an input transaction never yields a result in the very next cycle
  `TSG_ASSERT_NEXT(a_no_instant, s_tvalid && s_tready && !m_tvalid, !m_tvalid)
  // ready stays up until a transaction takes it
  `TSG_ASSERT_NEXT(a_ready_hold, s_tready && !s_tvalid, s_tready)

endmodule

bind tangent_space_generator tsg_checker u_tsg_checker (.*);
